// ===== sv/biq_pkg.sv =====
// Shared types and constants for the biquad IIR filter with nodata marks.
// Used by the configuration registers, the MAC datapath and the top level.
package biq_pkg;

  localparam int COEF_W             = 24;
  localparam int CFG_IDX_W          = 3;
  localparam int DEF_SAMPLE_WIDTH   = 24;
  localparam int DEF_COEF_FRAC_BITS = 22;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE = 3'd0,
    REG_COEF_A0       = 3'd1,
    REG_COEF_A1       = 3'd2,
    REG_COEF_A2       = 3'd3,
    REG_COEF_B1       = 3'd4,
    REG_COEF_B2       = 3'd5
  } biq_reg_t;

  typedef struct packed {
    logic                     filter_enable;
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } biq_cfg_t;

  // Flags that go with one result
  typedef struct packed {
    logic saturated;
    logic was_filtered;
    logic valid;
  } biq_flags_t;

endpackage

// ===== sv/biq_cfg.sv =====
// Configuration register bank of the biquad filter.
// Depends on biq_pkg for the register indexes and the coefficient struct.
module biq_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [biq_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [biq_pkg::COEF_W-1:0]     wr_data,
  output biq_pkg::biq_cfg_t              cfg
);
  import biq_pkg::*;

  biq_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_FILTER_ENABLE: cfg_nxt.filter_enable = wr_data[0];
        REG_COEF_A0:       cfg_nxt.a0 = $signed(wr_data);
        REG_COEF_A1:       cfg_nxt.a1 = $signed(wr_data);
        REG_COEF_A2:       cfg_nxt.a2 = $signed(wr_data);
        REG_COEF_B1:       cfg_nxt.b1 = $signed(wr_data);
        REG_COEF_B2:       cfg_nxt.b2 = $signed(wr_data);
        default:           cfg_nxt = cfg_r;  // drop writes past the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/biq_mac.sv =====
// Single-pass datapath of the biquad: five parallel products, sum, round,
// clamp and the passthrough select. Depends on biq_pkg.
module biq_mac #(
  parameter int SAMPLE_WIDTH   = biq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
  input  biq_pkg::biq_cfg_t              cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  input  logic                           hist_ok,
  input  logic signed [SAMPLE_WIDTH-1:0] x1,
  input  logic signed [SAMPLE_WIDTH-1:0] x2,
  input  logic signed [SAMPLE_WIDTH-1:0] y1,
  input  logic signed [SAMPLE_WIDTH-1:0] y2,
  output logic signed [SAMPLE_WIDTH-1:0] x0,
  output logic signed [SAMPLE_WIDTH-1:0] result,
  output biq_pkg::biq_flags_t            flags
);
  import biq_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int SUM_W  = PROD_W + 3;

  localparam logic signed [SUM_W-1:0] RND =
    {{(SUM_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] HI =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] LO = ~HI;

  logic signed [PROD_W-1:0] p_a0, p_a1, p_a2, p_b1, p_b2;
  logic signed [SUM_W-1:0]  sum, scaled;
  logic                     do_filt, sat_hi, sat_lo;

  assign x0 = sample_valid ? sample : '0;

  assign p_a0 = PROD_W'(cfg.a0) * PROD_W'(x0);
  assign p_a1 = PROD_W'(cfg.a1) * PROD_W'(x1);
  assign p_a2 = PROD_W'(cfg.a2) * PROD_W'(x2);
  assign p_b1 = PROD_W'(cfg.b1) * PROD_W'(y1);
  assign p_b2 = PROD_W'(cfg.b2) * PROD_W'(y2);

  assign sum = SUM_W'(p_a0) + SUM_W'(p_a1) + SUM_W'(p_a2)
             + SUM_W'(p_b1) + SUM_W'(p_b2) + RND;
  // round half up: floor of (sum + half) by arithmetic shift
  assign scaled = sum >>> COEF_FRAC_BITS;

  assign sat_hi  = scaled > HI;
  assign sat_lo  = scaled < LO;
  assign do_filt = cfg.filter_enable && sample_valid && hist_ok;

  always_comb begin
    result = x0;
    if (do_filt) begin
      priority if (sat_hi) begin
        result = HI[SAMPLE_WIDTH-1:0];
      end else if (sat_lo) begin
        result = LO[SAMPLE_WIDTH-1:0];
      end else begin
        result = scaled[SAMPLE_WIDTH-1:0];
      end
    end
  end

  assign flags.valid        = sample_valid;
  assign flags.was_filtered = do_filt;
  assign flags.saturated    = do_filt && (sat_hi || sat_lo);

endmodule

// ===== sv/biquad_iir_filter_with_nodata.sv =====
// Top level of the biquad IIR filter with nodata marks.
// Depends on biq_pkg, biq_cfg and biq_mac.
//
// Usage:
//  - Input stream in_*: in_tdata carries the sample, in_tuser[0] is
//    sample_valid (0 = nodata), in_tuser[1] is restart (clear all history
//    before this sample).
//  - Result stream out_*: out_tdata carries the filtered value, out_tuser
//    carries filtered_valid, was_filtered and saturated.
//  - Configuration: pulse cfg_wr_en with cfg_index and cfg_data; index 0 is
//    filter_enable, 1..5 are coef_a0, a1, a2, b1, b2 (signed Q2.22).
//    Write only while no request is in flight.
//  - Throughput is one request per cycle unless stalled. A result shows on
//    out_tvalid in the cycle after its request is taken; the whole MAC from
//    the history registers to the output register is combinational, so the
//    next request can use the new output history at once.
//  - When the receiver stalls, the result is held in the output register
//    and in_tready drops until it is taken; a request is accepted in the
//    same cycle the held result leaves.
//  - Reset clears the coefficients, disables the filter, marks all history
//    as nodata and empties the output register.
module biquad_iir_filter_with_nodata #(
  parameter int SAMPLE_WIDTH   = biq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,   // sample
  input  logic [1:0]                            in_tuser,   // sample_valid, restart
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,  // filtered
  output logic [2:0]                            out_tuser,  // filtered_valid,
                                                            // was_filtered, saturated
  input  logic                                  cfg_wr_en,
  input  logic [biq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]            cfg_data
);
  import biq_pkg::*;

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  biq_cfg_t   cfg;
  biq_flags_t flags;

  logic signed [SAMPLE_WIDTH-1:0] x0, result;
  logic signed [SAMPLE_WIDTH-1:0] xh0_r, xh1_r, yh0_r, yh1_r;
  logic                           xh0_v_r, xh1_v_r, yh0_v_r, yh1_v_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]              out_data_r;
  logic [2:0]                     out_user_r;
  logic                           accept, s_valid, s_restart, hist_ok;

  assign s_valid   = in_tuser[0];
  assign s_restart = in_tuser[1];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // restart wipes every history mark for this request
  assign hist_ok = !s_restart && xh0_v_r && xh1_v_r && yh0_v_r && yh1_v_r;

  biq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  biq_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .cfg          (cfg),
    .sample       ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .sample_valid (s_valid),
    .hist_ok      (hist_ok),
    .x1           (xh0_r),
    .x2           (xh1_r),
    .y1           (yh0_r),
    .y2           (yh1_r),
    .x0           (x0),
    .result       (result),
    .flags        (flags)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      xh0_v_r     <= 1'b0;
      xh1_v_r     <= 1'b0;
      yh0_v_r     <= 1'b0;
      yh1_v_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        xh1_v_r <= xh0_v_r && !s_restart;
        xh0_v_r <= s_valid;
        yh1_v_r <= yh0_v_r && !s_restart;
        yh0_v_r <= s_valid;
      end
    end
  end

  // payload: history values and the held result
  always_ff @(posedge clk) begin
    if (accept) begin
      xh1_r      <= xh0_r;
      xh0_r      <= x0;
      yh1_r      <= yh0_r;
      yh0_r      <= result;
      out_data_r <= DATA_W'($unsigned(result));
      out_user_r <= flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/biq_checker.sv =====
// Port-level checker for the biquad filter top level, with its bind.
// Depends on biq_pkg for the default sample width.
module biq_checker #(
  parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [1:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [2:0]                        out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_filt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("filtered result marked nodata");

  a_sat_filt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1])
    else $error("saturation on a passthrough result");

  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("nodata result carries a value");

  // a restart request always passes through
  a_restart_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[1] |=> out_tvalid && !out_tuser[1])
    else $error("restart request was filtered");

endmodule

bind biquad_iir_filter_with_nodata biq_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_biq_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for biquad_iir_filter_with_nodata: a directed table, then
// random phases that each write new coefficients. A built-in filter predictor works
// out every result the table lacks. Depends on biq_pkg and the RTL top level only.
module testbench;
  import biq_pkg::*;

  localparam int SW  = DEF_SAMPLE_WIDTH;
  localparam int CFB = DEF_COEF_FRAC_BITS;
  localparam int TW  = ((SW + 7) / 8) * 8;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int DRAIN_CYCLES    = 3;
  localparam int QUIET_LIMIT     = 2000;

  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  localparam longint SMP_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMP_LO = -SMP_HI - 1;
  localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW - 1){1'b0}}};

  localparam logic [COEF_W-1:0] COEF_MAX     = 24'h7FFFFF;
  localparam logic [COEF_W-1:0] COEF_MIN     = 24'h800000;
  localparam logic [COEF_W-1:0] COEF_ONE     = 24'h400000;
  localparam logic [COEF_W-1:0] COEF_HALF    = 24'h200000;
  localparam logic [COEF_W-1:0] COEF_NEG_ONE = 24'hC00000;

  localparam biq_flags_t FL_NONE = '{saturated: 1'b0, was_filtered: 1'b0, valid: 1'b0};
  localparam biq_flags_t FL_PASS = '{saturated: 1'b0, was_filtered: 1'b0, valid: 1'b1};
  localparam biq_flags_t FL_FILT = '{saturated: 1'b0, was_filtered: 1'b1, valid: 1'b1};
  localparam biq_flags_t FL_SAT  = '{saturated: 1'b1, was_filtered: 1'b1, valid: 1'b1};

  typedef struct {
    logic [SW-1:0] value;
    biq_flags_t    flags;
  } filt_result_t;

  typedef struct {
    longint value;
    bit     ok;
  } hist_t;

  typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
    bit                   valid;
    bit                   restart;
    bit                   known;
    filt_result_t         want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TW-1:0]        in_tdata = '0;   // sample
  logic [1:0]           in_tuser = '0;   // sample_valid, restart
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TW-1:0]        out_tdata;       // filtered
  logic [2:0]           out_tuser;       // filtered_valid, was_filtered, saturated
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  // predictor state: register shadow and both histories, all zero at reset
  bit                     filt_on;
  bit signed [COEF_W-1:0] tap_a [3];
  bit signed [COEF_W-1:0] tap_b [2];
  hist_t                  x_hist [2];
  hist_t                  y_hist [2];

  filt_result_t pending_results [$];
  int unsigned  mismatch_cnt;
  bit           steady;

  biquad_iir_filter_with_nodata i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic filt_result_t biquad_predict(logic [SW-1:0] smp, bit vld, bit rst_hist);
    filt_result_t r;
    longint       x0, acc, q;
    x0 = vld ? longint'($signed(smp)) : 0;
    if (rst_hist) begin
      foreach (x_hist[k]) begin
        x_hist[k].ok = 1'b0;
        y_hist[k].ok = 1'b0;
      end
    end
    q = x0;
    r.flags = FL_NONE;
    r.flags.valid = vld;
    if (filt_on && vld && x_hist[0].ok && x_hist[1].ok && y_hist[0].ok && y_hist[1].ok) begin
      acc = longint'(tap_a[0]) * x0
          + longint'(tap_a[1]) * x_hist[0].value
          + longint'(tap_a[2]) * x_hist[1].value
          + longint'(tap_b[0]) * y_hist[0].value
          + longint'(tap_b[1]) * y_hist[1].value;
      // round half up, then back to sample scale
      acc = acc + (longint'(1) <<< (CFB - 1));
      q = acc >>> CFB;
      if (q > SMP_HI) begin
        q = SMP_HI;
        r.flags.saturated = 1'b1;
      end else if (q < SMP_LO) begin
        q = SMP_LO;
        r.flags.saturated = 1'b1;
      end
      r.flags.was_filtered = 1'b1;
    end
    x_hist[1] = x_hist[0];
    x_hist[0] = '{value: x0, ok: vld};
    y_hist[1] = y_hist[0];
    y_hist[0] = '{value: q, ok: vld};
    r.value = q[SW-1:0];
    return r;
  endfunction

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Offer one request after a random gap; predict its result once taken.
  task automatic push_sample(input logic [SW-1:0] smp, input bit vld, input bit rst_hist,
                             input bit known, input filt_result_t typed);
    int unsigned  gap;
    filt_result_t predicted;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TW'(smp);
    in_tuser  <= {rst_hist, vld};
    do @(posedge clk); while (!in_tready);
    predicted = biquad_predict(smp, vld, rst_hist);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // Hold requests back until every result is out.
  task automatic drain_stream();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FILTER_ENABLE: filt_on  = val[0];
      REG_COEF_A0:       tap_a[0] = val;
      REG_COEF_A1:       tap_a[1] = val;
      REG_COEF_A2:       tap_a[2] = val;
      REG_COEF_B1:       tap_b[0] = val;
      REG_COEF_B2:       tap_b[1] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] draw_coef(int unsigned style, bit feedback);
    logic [COEF_W-1:0] c;
    case (style)
      0: begin
        // mild taps keep the loop stable
        c = COEF_W'($urandom_range(0, feedback ? 24'h0FFFFF : 24'h1FFFFF));
        c = c - (feedback ? 24'h080000 : 24'h100000);
      end
      1: begin
        case ($urandom_range(0, 4))
          0: c = COEF_MAX;
          1: c = COEF_MIN;
          2: c = '0;
          3: c = COEF_ONE;
          default: c = COEF_NEG_ONE;
        endcase
      end
      default: c = COEF_W'($urandom());
    endcase
    return c;
  endfunction

  function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    dir_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: val, valid: 1'b0, restart: 1'b0, known: 1'b0,
          want: '{value: '0, flags: FL_NONE}};
    return r;
  endfunction

  function automatic dir_row_t row_in(logic [SW-1:0] smp, bit vld, bit rst_hist);
    dir_row_t r;
    r = '{kind: ROW_SAMPLE, idx: '0, data: smp, valid: vld, restart: rst_hist, known: 1'b0,
          want: '{value: '0, flags: FL_NONE}};
    return r;
  endfunction

  function automatic dir_row_t row_chk(logic [SW-1:0] smp, bit vld, bit rst_hist,
                                       logic [SW-1:0] res, biq_flags_t fl);
    dir_row_t r;
    r = row_in(smp, vld, rst_hist);
    r.known = 1'b1;
    r.want  = '{value: res, flags: fl};
    return r;
  endfunction

  // result side: random stalls, compare against the oldest expectation
  initial begin : result_sink
    int unsigned  hold;
    filt_result_t want;
    biq_flags_t   got_fl;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got_fl = biq_flags_t'(out_tuser);
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, got value %0d flags %b",
                   $time, $signed(out_tdata[SW-1:0]), out_tuser);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("filtered", int'($signed(want.value)),
                        int'($signed(out_tdata[SW-1:0])));
          compare_field("filtered_valid", int'(want.flags.valid), int'(got_fl.valid));
          compare_field("was_filtered", int'(want.flags.was_filtered),
                        int'(got_fl.was_filtered));
          compare_field("saturated", int'(want.flags.saturated), int'(got_fl.saturated));
        end
        hold = draw_gap();
        if (hold != 0) out_tready <= 1'b0;
      end else if (!out_tready) begin
        if (hold > 1) begin
          hold--;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** biquad_iir_filter_with_nodata: FAILED **");
    $finish;
  end

  initial begin : stimulus
    dir_row_t          directed_tbl [$];
    filt_result_t      no_typed;
    logic [SW-1:0]     smp;
    logic [COEF_W-1:0] en_word;
    bit                vld, rst_hist;
    int                phase;

    no_typed = '{value: '0, flags: FL_NONE};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_tbl = '{
      // after reset: filter off, passthrough and nodata
      row_chk(SMP_MAX, 1'b1, 1'b0, SMP_MAX, FL_PASS),
      row_chk(SMP_MIN, 1'b1, 1'b0, SMP_MIN, FL_PASS),
      row_chk(24'h5A5A5A, 1'b0, 1'b0, '0, FL_NONE),
      row_chk(24'hFFFFFF, 1'b0, 1'b1, '0, FL_NONE),
      row_cfg(REG_FILTER_ENABLE, 24'h000001),
      row_cfg(REG_COEF_A0, COEF_ONE),
      row_cfg(REG_COEF_A1, '0),
      row_cfg(REG_COEF_A2, '0),
      row_cfg(REG_COEF_B1, '0),
      row_cfg(REG_COEF_B2, '0),
      row_cfg(IDX_SPARE_A, 24'hFFFFFF),
      row_cfg(IDX_SPARE_B, 24'h800001),
      // restart and one more sample fill the history before the formula applies
      row_chk(100, 1'b1, 1'b1, 100, FL_PASS),
      row_chk(200, 1'b1, 1'b0, 200, FL_PASS),
      row_chk(300, 1'b1, 1'b0, 300, FL_FILT),
      row_chk(-7, 1'b1, 1'b0, -7, FL_FILT),
      row_cfg(REG_COEF_A0, COEF_MAX),
      row_chk(SMP_MAX, 1'b1, 1'b0, SMP_MAX, FL_SAT),
      row_chk(SMP_MIN, 1'b1, 1'b0, SMP_MIN, FL_SAT),
      row_cfg(REG_COEF_A0, COEF_MIN),
      row_chk(SMP_MAX, 1'b1, 1'b0, SMP_MIN, FL_SAT),
      row_chk(SMP_MIN, 1'b1, 1'b0, SMP_MAX, FL_SAT),
      row_chk('0, 1'b1, 1'b0, '0, FL_FILT),
      row_cfg(REG_COEF_A0, COEF_HALF),
      row_cfg(REG_COEF_A1, COEF_HALF),
      row_cfg(REG_COEF_A2, COEF_MIN),
      row_cfg(REG_COEF_B1, COEF_MAX),
      row_cfg(REG_COEF_B2, COEF_NEG_ONE),
      row_in(12345, 1'b1, 1'b0),
      row_in(-54321, 1'b1, 1'b0),
      row_in(SMP_MAX, 1'b1, 1'b0),
      // nodata in mid stream breaks the history until refilled
      row_chk(24'h000309, 1'b0, 1'b0, '0, FL_NONE),
      row_chk(1000, 1'b1, 1'b0, 1000, FL_PASS),
      row_in(2000, 1'b1, 1'b0),
      row_in(3000, 1'b1, 1'b0),
      // disabled: histories keep shifting; upper enable bits are don't-care
      row_cfg(REG_FILTER_ENABLE, 24'hFFFFFE),
      row_chk(4000, 1'b1, 1'b0, 4000, FL_PASS),
      row_chk(-4000, 1'b1, 1'b0, -4000, FL_PASS),
      row_cfg(REG_FILTER_ENABLE, 24'h000001),
      row_in(5, 1'b1, 1'b0)
    };

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ROW_CFG) begin
        drain_stream();
        reg_write(directed_tbl[i].idx, directed_tbl[i].data);
      end else begin
        push_sample(directed_tbl[i].data, directed_tbl[i].valid, directed_tbl[i].restart,
                    directed_tbl[i].known, directed_tbl[i].want);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      drain_stream();
      steady  = (phase % 4 == 3);
      en_word = COEF_W'($urandom());
      en_word[0] = (phase != 1);
      reg_write(REG_FILTER_ENABLE, en_word);
      reg_write(REG_COEF_A0, draw_coef(phase % 3, 1'b0));
      reg_write(REG_COEF_A1, draw_coef(phase % 3, 1'b0));
      reg_write(REG_COEF_A2, draw_coef(phase % 3, 1'b0));
      reg_write(REG_COEF_B1, draw_coef(phase % 3, 1'b1));
      reg_write(REG_COEF_B2, draw_coef(phase % 3, 1'b1));
      reg_write((phase % 2 != 0) ? IDX_SPARE_A : IDX_SPARE_B, COEF_W'($urandom()));
      repeat (ITEMS_PER_PHASE) begin
        vld      = ($urandom_range(0, 99) >= 6);
        rst_hist = ($urandom_range(0, 99) < 3);
        case ($urandom_range(0, 7))
          0: smp = ($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN;
          1, 2, 3: smp = SW'($urandom_range(0, 2047) - 1024);
          default: smp = SW'($urandom());
        endcase
        push_sample(smp, vld, rst_hist, 1'b0, no_typed);
      end
    end

    drain_stream();
    if (mismatch_cnt == 0) begin
      $display("** biquad_iir_filter_with_nodata: PASSED **");
    end else begin
      $display("** biquad_iir_filter_with_nodata: FAILED **");
    end
    $finish;
  end

endmodule
